// ===== hdl/urhc_pkg.sv =====
// Shared types and constants for the ultrasonic ranger with hit confirmation.
`timescale 1ns / 1ps

package urhc_pkg;

	// Widths of the configuration and result fields.
	localparam int unsigned ShortW = 8;
	localparam int unsigned LongW  = 16;
	localparam int unsigned IndexW = 3;
	localparam int unsigned CfgDataW = 16;

	// Register reset values.
	localparam logic [ShortW-1:0] PreLowReset   = 8'd2;
	localparam logic [ShortW-1:0] PulseReset    = 8'd10;
	localparam logic [LongW-1:0]  TimeoutReset  = 16'd10000;
	localparam logic [LongW-1:0]  NearReset     = 16'd2400;
	localparam logic [ShortW-1:0] ConfirmReset  = 8'd4;

	localparam logic [LongW-1:0]  TicksMax  = 16'hFFFF;
	localparam logic [ShortW-1:0] StreakMax = 8'hFF;

	// Configuration register indexes.
	typedef enum logic [IndexW-1:0] {
		REG_PRE_LOW  = 3'd0,
		REG_PULSE    = 3'd1,
		REG_TIMEOUT  = 3'd2,
		REG_NEAR     = 3'd3,
		REG_CONFIRM  = 3'd4
	} reg_index_t;

	// Measurement phases.
	typedef enum logic [1:0] {
		PH_PRE   = 2'd0,
		PH_PULSE = 2'd1,
		PH_RISE  = 2'd2,
		PH_FALL  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [ShortW-1:0] pre_low_ticks;
		logic [ShortW-1:0] pulse_ticks;
		logic [LongW-1:0]  timeout_ticks;
		logic [LongW-1:0]  near_threshold;
		logic [ShortW-1:0] confirm_count;
	} cfg_t;

	typedef struct packed {
		logic              trigger_level;
		logic              measure_done;
		logic              timed_out;
		logic [LongW-1:0]  echo_ticks;
		logic              is_near;
		logic [ShortW-1:0] hit_run;
		logic              obstacle_confirmed;
	} result_t;

endpackage

// ===== hdl/urhc_step.sv =====
// Per-tick next-state and result logic of the ranging sequencer.
`timescale 1ns / 1ps

module urhc_step import urhc_pkg::*; (
	input  cfg_t              cfg,
	input  phase_t            phase,
	input  logic [LongW-1:0]  tick_left,
	input  logic [ShortW-1:0] hit_streak,
	input  logic              echo,
	output phase_t            phase_next,
	output logic [LongW-1:0]  tick_left_next,
	output logic [ShortW-1:0] hit_streak_next,
	output result_t           result
);

	logic [LongW-1:0]  limit;
	logic [LongW-1:0]  elapsed;
	logic              limit_hit;
	logic              finish_fall;
	logic              finish_tmo;
	logic              finish;
	logic              near;
	logic [LongW-1:0]  pre_load;
	logic [LongW-1:0]  pulse_load;

	// A zero timeout or phase length behaves as one tick.
	assign limit      = (cfg.timeout_ticks == '0) ? LongW'(1) : cfg.timeout_ticks;
	assign pre_load   = (cfg.pre_low_ticks == '0) ? LongW'(1) : LongW'(cfg.pre_low_ticks);
	assign pulse_load = (cfg.pulse_ticks == '0) ? LongW'(1) : LongW'(cfg.pulse_ticks);

	// In the wait phases the elapsed count saturates before it is examined.
	assign elapsed   = (tick_left == TicksMax) ? tick_left : tick_left + LongW'(1);
	assign limit_hit = (elapsed >= limit);

	assign finish_fall = (phase == PH_FALL) && !echo;
	assign finish_tmo  = ((phase == PH_RISE) && limit_hit) ||
	                     ((phase == PH_FALL) && echo && limit_hit);
	assign finish      = finish_fall || finish_tmo;
	assign near        = finish_fall && (elapsed <= cfg.near_threshold);

	// Next state.
	always_comb begin
		phase_next     = phase;
		tick_left_next = tick_left;
		if (finish) begin
			phase_next     = PH_PRE;
			tick_left_next = pre_load;
		end else begin
			case (phase)
				PH_PULSE: begin
					if (tick_left <= LongW'(1)) begin
						phase_next     = PH_RISE;
						tick_left_next = '0;
					end else begin
						tick_left_next = tick_left - LongW'(1);
					end
				end
				PH_RISE: begin
					tick_left_next = elapsed;
					if (echo) begin
						phase_next = PH_FALL;
					end
				end
				PH_FALL: begin
					tick_left_next = elapsed;
				end
				default: begin
					if (tick_left <= LongW'(1)) begin
						phase_next     = PH_PULSE;
						tick_left_next = pulse_load;
					end else begin
						tick_left_next = tick_left - LongW'(1);
					end
				end
			endcase
		end
	end

	// Result fields and the near-hit run.
	always_comb begin
		hit_streak_next = hit_streak;
		if (finish) begin
			if (near) begin
				hit_streak_next = (hit_streak == StreakMax) ? hit_streak
				                                            : hit_streak + ShortW'(1);
			end else begin
				hit_streak_next = '0;
			end
		end
		result.trigger_level      = (phase == PH_PULSE);
		result.measure_done       = finish;
		result.timed_out          = finish_tmo;
		result.echo_ticks         = finish_fall ? elapsed : (finish_tmo ? TicksMax : '0);
		result.is_near            = near;
		result.hit_run            = hit_streak_next;
		result.obstacle_confirmed = (hit_streak_next >= cfg.confirm_count);
	end

endmodule

// ===== hdl/urhc_skid.sv =====
// Output register with one skid entry for the result channel.
`timescale 1ns / 1ps

module urhc_skid import urhc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop_stall,
	output logic    pop_valid,
	output result_t pop_data,
	output logic    full
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    take;

	assign take      = main_valid_q && !pop_stall;
	assign pop_valid = main_valid_q;
	assign pop_data  = main_q;
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_valid_q || take) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!main_valid_q || take) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

// ===== hdl/ultrasonic_ranger_with_hit_confirm.sv =====
// Top level of the ultrasonic ranger with near-hit confirmation.
//
//   Channel  Direction  Handshake             Carries
//   in       into       in_valid / in_stall   echo_level, one request per tick
//   out      out of     out_valid / out_stall trigger and measurement result
//   cfg      into       cfg_valid / cfg_ready register index and write data
//
// Every accepted tick request produces exactly one result request. The state
// update and result are computed in the same cycle the tick is accepted and
// land in the output register, or in the skid entry while that register is
// held, so one request is taken per cycle while the input does not stall. A
// one-entry skid buffer behind the output register lets the input keep
// flowing while a result waits; the input stalls only when both entries hold
// results. Reset puts the sequencer into the pre-low phase with the register
// defaults loaded. Configuration writes are always ready.
`timescale 1ns / 1ps

module ultrasonic_ranger_with_hit_confirm import urhc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Tick channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                echo_level,
	// Result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                trigger_level,
	output logic                measure_done,
	output logic                timed_out,
	output logic [LongW-1:0]    echo_ticks,
	output logic                is_near,
	output logic [ShortW-1:0]   hit_run,
	output logic                obstacle_confirmed,
	// Configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [IndexW-1:0]   cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t              cfg_q;
	phase_t            phase_q;
	logic [LongW-1:0]  tick_left_q;
	logic [ShortW-1:0] hit_streak_q;

	phase_t            phase_next;
	logic [LongW-1:0]  tick_left_next;
	logic [ShortW-1:0] hit_streak_next;
	result_t           step_result;
	result_t           out_result;
	logic              accept;
	logic              skid_full;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_full;
	assign accept    = in_valid && !in_stall;

	// Register file. Indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_low_ticks  <= PreLowReset;
			cfg_q.pulse_ticks    <= PulseReset;
			cfg_q.timeout_ticks  <= TimeoutReset;
			cfg_q.near_threshold <= NearReset;
			cfg_q.confirm_count  <= ConfirmReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PRE_LOW: cfg_q.pre_low_ticks  <= cfg_data[ShortW-1:0];
				REG_PULSE:   cfg_q.pulse_ticks    <= cfg_data[ShortW-1:0];
				REG_TIMEOUT: cfg_q.timeout_ticks  <= cfg_data[LongW-1:0];
				REG_NEAR:    cfg_q.near_threshold <= cfg_data[LongW-1:0];
				REG_CONFIRM: cfg_q.confirm_count  <= cfg_data[ShortW-1:0];
				default: begin
				end
			endcase
		end
	end

	urhc_step u_step (
		.cfg             (cfg_q),
		.phase           (phase_q),
		.tick_left       (tick_left_q),
		.hit_streak      (hit_streak_q),
		.echo            (echo_level),
		.phase_next      (phase_next),
		.tick_left_next  (tick_left_next),
		.hit_streak_next (hit_streak_next),
		.result          (step_result)
	);

	// Sequencer state advances once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_PRE;
			tick_left_q  <= LongW'(PreLowReset);
			hit_streak_q <= '0;
		end else if (accept) begin
			phase_q      <= phase_next;
			tick_left_q  <= tick_left_next;
			hit_streak_q <= hit_streak_next;
		end
	end

	urhc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (step_result),
		.pop_stall (out_stall),
		.pop_valid (out_valid),
		.pop_data  (out_result),
		.full      (skid_full)
	);

	assign trigger_level      = out_result.trigger_level;
	assign measure_done       = out_result.measure_done;
	assign timed_out          = out_result.timed_out;
	assign echo_ticks         = out_result.echo_ticks;
	assign is_near            = out_result.is_near;
	assign hit_run            = out_result.hit_run;
	assign obstacle_confirmed = out_result.obstacle_confirmed;

`ifndef NO_ASSERTIONS
	// A waiting skid entry implies the output register is occupied.
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full |-> out_valid)
		else $error("skid entry held while output register empty");

	// A timeout result carries the all-ones distance and is never near.
	a_timeout_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && timed_out) |-> (measure_done && echo_ticks == TicksMax && !is_near))
		else $error("timeout result fields inconsistent");

	// A near result only comes with a finished measurement and a nonzero run.
	a_near_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_near) |-> (measure_done && !timed_out && hit_run != '0))
		else $error("near result without a finished measurement");

	// A tick accepted in the pulse phase drives the trigger in its result.
	a_pulse_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_PULSE && !skid_full && !(out_valid && out_stall))
		|=> (out_valid && trigger_level))
		else $error("pulse phase tick did not drive the trigger");
`endif

endmodule

// ===== tb/urhc_checker.sv =====
// Result checker for the ultrasonic ranger: predicts every tick and compares the results.
`timescale 1ns / 1ps

module urhc_checker import urhc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                echo_level,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                trigger_level,
	input  logic                measure_done,
	input  logic                timed_out,
	input  logic [LongW-1:0]    echo_ticks,
	input  logic                is_near,
	input  logic [ShortW-1:0]   hit_run,
	input  logic                obstacle_confirmed,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [IndexW-1:0]   cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output int                  mismatches,
	output int                  outstanding
);

	localparam int ReportLimit = 10;

	cfg_t              regs;
	phase_t            phase;
	logic [LongW-1:0]  tick_left;
	logic [ShortW-1:0] hit_streak;
	result_t           pending_results[$];
	int                error_total;
	int                result_idx;

	// Zero counts behave as one.
	function automatic logic [LongW-1:0] floor_one(input logic [LongW-1:0] v);
		return (v == '0) ? LongW'(1) : v;
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf("trig=%0b done=%0b tmo=%0b ticks=%0d near=%0b run=%0d conf=%0b",
			r.trigger_level, r.measure_done, r.timed_out, r.echo_ticks, r.is_near,
			r.hit_run, r.obstacle_confirmed);
	endfunction

	// Advances the ranging sequencer by one tick and returns the result of that tick.
	function automatic result_t advance_ranger(input logic echo);
		result_t          r;
		logic [LongW-1:0] limit;
		logic             fell;
		logic             expired;
		r       = '0;
		fell    = 1'b0;
		expired = 1'b0;
		limit   = floor_one(regs.timeout_ticks);
		case (phase)
			PH_PULSE: begin
				r.trigger_level = 1'b1;
				if (tick_left <= LongW'(1)) begin
					phase     = PH_RISE;
					tick_left = '0;
				end else begin
					tick_left = tick_left - LongW'(1);
				end
			end
			PH_RISE, PH_FALL: begin
				// The elapsed count moves first, then the echo is looked at.
				if (tick_left != TicksMax)
					tick_left = tick_left + LongW'(1);
				if (phase == PH_RISE) begin
					if (tick_left >= limit)
						expired = 1'b1;
					else if (echo)
						phase = PH_FALL;
				end else begin
					if (!echo)
						fell = 1'b1;
					else if (tick_left >= limit)
						expired = 1'b1;
				end
			end
			default: begin
				if (tick_left <= LongW'(1)) begin
					phase     = PH_PULSE;
					tick_left = floor_one(LongW'(regs.pulse_ticks));
				end else begin
					tick_left = tick_left - LongW'(1);
				end
			end
		endcase

		if (fell || expired) begin
			r.measure_done = 1'b1;
			if (fell) begin
				r.echo_ticks = tick_left;
				r.is_near    = (tick_left <= regs.near_threshold);
			end else begin
				r.timed_out  = 1'b1;
				r.echo_ticks = TicksMax;
			end
			if (r.is_near) begin
				if (hit_streak != StreakMax)
					hit_streak = hit_streak + ShortW'(1);
			end else begin
				hit_streak = '0;
			end
			phase     = PH_PRE;
			tick_left = floor_one(LongW'(regs.pre_low_ticks));
		end
		r.hit_run            = hit_streak;
		r.obstacle_confirmed = (hit_streak >= regs.confirm_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			regs = '{pre_low_ticks: PreLowReset, pulse_ticks: PulseReset,
				timeout_ticks: TimeoutReset, near_threshold: NearReset,
				confirm_count: ConfirmReset};
			phase       = PH_PRE;
			tick_left   = LongW'(PreLowReset);
			hit_streak  = '0;
			error_total = 0;
			result_idx  = 0;
			pending_results.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PRE_LOW: regs.pre_low_ticks  = cfg_data[ShortW-1:0];
					REG_PULSE:   regs.pulse_ticks    = cfg_data[ShortW-1:0];
					REG_TIMEOUT: regs.timeout_ticks  = cfg_data[LongW-1:0];
					REG_NEAR:    regs.near_threshold = cfg_data[LongW-1:0];
					REG_CONFIRM: regs.confirm_count  = cfg_data[ShortW-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pending_results.push_back(advance_ranger(echo_level));
			if (out_valid && !out_stall) begin
				got = {trigger_level, measure_done, timed_out, echo_ticks, is_near,
					hit_run, obstacle_confirmed};
				if (pending_results.size() == 0) begin
					error_total++;
					if (error_total <= ReportLimit)
						$display("result %0d arrived with no tick pending: %s",
							result_idx, describe(got));
				end else begin
					want = pending_results.pop_front();
					if (got.trigger_level !== want.trigger_level ||
							got.measure_done !== want.measure_done ||
							got.timed_out !== want.timed_out ||
							got.echo_ticks !== want.echo_ticks ||
							got.is_near !== want.is_near ||
							got.hit_run !== want.hit_run ||
							got.obstacle_confirmed !== want.obstacle_confirmed) begin
						error_total++;
						if (error_total <= ReportLimit)
							$display("result %0d mismatch: expected %s, got %s",
								result_idx, describe(want), describe(got));
					end
				end
				result_idx++;
			end
			mismatches  <= error_total;
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== tb/ultrasonic_ranger_with_hit_confirm_tb.sv =====
// Testbench top for the ultrasonic ranger: stimulus, back pressure and the final verdict.
`timescale 1ns / 1ps

// The block takes one tick request per unstalled cycle, each with a sampled echo
// level, and returns one result request per tick. The checker beside the block
// keeps a copy of the ranging sequencer and compares every result; this module
// only makes requests, applies back pressure and decides pass or fail at the end.
//
// The run goes through a short directed part that walks the measurement corner
// cases, then several random phases, each under its own register settings. The
// registers are rewritten only once every tick already sent has produced its
// result, so the block is idle (apart from its sequencer state) during a write.
module ultrasonic_ranger_with_hit_confirm_tb;
	import urhc_pkg::*;

	// Length of the deliberate receiver hold-off, long enough to fill the block.
	localparam int HoldCycles = 60;
	// Number of random phases, each with its own register settings.
	localparam int PhaseCount = 6;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                echo_level;
	logic                out_valid;
	logic                out_stall;
	logic                trigger_level;
	logic                measure_done;
	logic                timed_out;
	logic [LongW-1:0]    echo_ticks;
	logic                is_near;
	logic [ShortW-1:0]   hit_run;
	logic                obstacle_confirmed;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IndexW-1:0]   cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	int mismatches;
	int outstanding;
	// Set by the stimulus to ask the result side for one long hold-off.
	bit hold_request;

	// 20 ns clock period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	ultrasonic_ranger_with_hit_confirm u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.echo_level         (echo_level),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.trigger_level      (trigger_level),
		.measure_done       (measure_done),
		.timed_out          (timed_out),
		.echo_ticks         (echo_ticks),
		.is_near            (is_near),
		.hit_run            (hit_run),
		.obstacle_confirmed (obstacle_confirmed),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	urhc_checker u_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.echo_level         (echo_level),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.trigger_level      (trigger_level),
		.measure_done       (measure_done),
		.timed_out          (timed_out),
		.echo_ticks         (echo_ticks),
		.is_near            (is_near),
		.hit_run            (hit_run),
		.obstacle_confirmed (obstacle_confirmed),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.mismatches         (mismatches),
		.outstanding        (outstanding)
	);

	// Offers one register write and waits for it to be taken. The valid is left high
	// so that back-to-back writes never lower and raise it within one time step;
	// set_config lowers it after the last write.
	task automatic write_reg(input logic [IndexW-1:0] idx, input logic [CfgDataW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Writes all five registers. The 8-bit registers get random junk in the upper
	// data byte, which the block must drop. A write to an unused index goes last,
	// so an index decoder that aliases it onto a real register would show up.
	task automatic set_config(input logic [ShortW-1:0] pre, input logic [ShortW-1:0] pulse,
			input logic [LongW-1:0] timeout, input logic [LongW-1:0] near,
			input logic [ShortW-1:0] confirm);
		write_reg(REG_PRE_LOW, {8'($urandom), pre});
		write_reg(REG_PULSE, {8'($urandom), pulse});
		write_reg(REG_TIMEOUT, timeout);
		write_reg(REG_NEAR, near);
		write_reg(REG_CONFIRM, {8'($urandom), confirm});
		write_reg(IndexW'($urandom_range(REG_CONFIRM + 1, (1 << IndexW) - 1)),
			16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Sends one tick request, then maybe leaves a gap. Most gaps are absent or
	// short, a few are long. When there is no gap the valid simply stays high and
	// the next call puts the new echo level on the same edge.
	task automatic send_tick(input logic level);
		int roll;
		int gap;
		in_valid   <= 1'b1;
		echo_level <= level;
		do @(posedge clk); while (in_stall);
		roll = $urandom_range(0, 99);
		if (roll < 60)
			gap = 0;
		else if (roll < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every tick sent has produced its result. The
	// first edge is always taken, since the count seen at an edge does not yet
	// include a tick accepted on that same edge.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Sends a stream of ticks shaped like a real echo line: runs of low and high of
	// random length up to span, with an occasional single-tick glitch thrown in.
	// With toggle set the echo simply alternates every tick, which lines up with the
	// shortest measurement cycle and ends every measurement by a fall.
	task automatic feed_ticks(input int count, input int span, input bit toggle);
		logic level;
		int   run_left;
		level    = 1'($urandom);
		run_left = 0;
		for (int i = 0; i < count; i++) begin
			if (toggle) begin
				level = !level;
				send_tick(level);
			end else begin
				if (run_left == 0) begin
					level    = !level;
					run_left = $urandom_range(1, span);
				end
				run_left--;
				send_tick(($urandom_range(0, 9) == 0) ? !level : level);
			end
		end
	endtask

	// Result side back pressure. It alternates stretches with no stall and stall
	// bursts, mostly short ones with a few long. When the stimulus asks for it, it
	// holds the result channel off once for a long stretch so that both entries of
	// the block fill and the tick channel stalls.
	initial begin : result_side
		int roll;
		int span;
		bit held;
		out_stall = 1'b0;
		held      = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request && !held) begin
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				held = 1'b1;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 45) begin
					out_stall <= 1'b0;
					span = $urandom_range(1, 20);
				end else begin
					out_stall <= 1'b1;
					span = (roll < 92) ? $urandom_range(1, 3) : $urandom_range(10, 30);
				end
				repeat (span) @(posedge clk);
			end
		end
	end

	// Directed echo levels, sent from the left. After reset the pre-low count is
	// still the default of two, so the first group has an extra leading tick. With
	// both trigger phases at one tick and a timeout of three, the groups give in turn:
	// a fall on the second wait tick, which is near; a fall on the timeout tick,
	// which wins over the timeout; a rise on the timeout tick, which times out at
	// once; and an echo that stays high until the timeout.
	localparam bit [19:0] MeasureEcho = 20'b10110_01110_10001_01111;
	// Five ticks that leave the block waiting for a rise with the timeout at its
	// maximum; the timeout is then cut below the elapsed count for one more tick.
	localparam bit [4:0] WaitingEcho = 5'b01000;

	initial begin : stimulus
		int p;
		in_valid     = 1'b0;
		echo_level   = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		hold_request = 1'b0;
		arst_n       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero trigger counts run one tick each, and a zero confirm count keeps the
		// confirm flag up whatever the hit run is.
		set_config(8'd0, 8'd0, 16'd3, 16'd2, 8'd0);
		for (int i = $bits(MeasureEcho) - 1; i >= 0; i--)
			send_tick(MeasureEcho[i]);
		wait_drained();
		set_config(8'd0, 8'd0, TicksMax, 16'd2, 8'd0);
		for (int i = $bits(WaitingEcho) - 1; i >= 0; i--)
			send_tick(WaitingEcho[i]);
		// A zero timeout acts as one, which the elapsed count already exceeds.
		wait_drained();
		set_config(8'd0, 8'd0, 16'd0, 16'd2, 8'd0);
		send_tick(1'b1);

		for (p = 0; p < PhaseCount; p++) begin
			// The sender pauses here until every result of the last phase is in.
			wait_drained();
			case (p)
				0: begin
					// Short everything, with the long receiver hold-off on top.
					set_config(8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
						16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
						8'($urandom_range(0, 3)));
					hold_request = 1'b1;
					feed_ticks(100, 12, 1'b0);
				end
				1: begin
					// Longest timeout and a zero threshold, so nothing is ever near.
					set_config(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
						TicksMax, 16'd0, 8'd1);
					feed_ticks(100, 24, 1'b0);
				end
				2: begin
					// Zero timeout: every wait tick ends the measurement. This phase
					// likely starts with the elapsed count far above the new timeout.
					set_config(8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
						16'd0, TicksMax, StreakMax);
					feed_ticks(60, 4, 1'b0);
				end
				3: begin
					// Every measurement is near and takes four ticks, so the hit run
					// climbs past the confirm count and the confirm flag rises.
					set_config(8'd0, 8'd0, TicksMax, TicksMax, 8'd20);
					feed_ticks(150, 1, 1'b1);
				end
				4: begin
					set_config(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
						16'($urandom_range(1, 30)), 16'($urandom_range(0, 30)),
						8'($urandom));
					feed_ticks(150, 8, 1'b0);
				end
				default: begin
					// Longest trigger phases, long enough to see a full measurement.
					set_config(StreakMax, StreakMax, 16'($urandom_range(3, 12)),
						16'($urandom_range(0, 12)), 8'd2);
					feed_ticks(580, 6, 1'b0);
				end
			endcase
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Safety net: 10 ms is several times the slowest correct run.
	initial begin : watchdog
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/urhc_pkg.sv
hdl/urhc_step.sv
hdl/urhc_skid.sv
hdl/ultrasonic_ranger_with_hit_confirm.sv
tb/urhc_checker.sv
tb/ultrasonic_ranger_with_hit_confirm_tb.sv
